### hdl/mkds_pkg.sv
// Shared types and constants for the motorized knob detent snap controller.
package mkds_pkg;

    localparam int PosW     = 11;
    localparam int IdW      = 16;
    localparam int LevelW   = 3;
    localparam int ModeW    = 2;
    localparam int NDetents = 5;
    localparam int CfgDataW = 32;
    localparam int CfgAddrW = 5;
    localparam int CfgIdxW  = 3;

    // controller modes
    localparam logic [ModeW-1:0] MODE_UNKNOWN   = 2'd0;
    localparam logic [ModeW-1:0] MODE_RESETTING = 2'd1;
    localparam logic [ModeW-1:0] MODE_ACCEPTING = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [CfgIdxW-1:0] REG_DETENT_0  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_DETENT_1  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_DETENT_2  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_DETENT_3  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_DETENT_4  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_RESET_TOL = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_SNAP_TOL  = 3'd6;

    // reset values
    localparam logic [PosW-1:0] DETENT_0_RST  = 11'd0;
    localparam logic [PosW-1:0] DETENT_1_RST  = 11'd400;
    localparam logic [PosW-1:0] DETENT_2_RST  = 11'd800;
    localparam logic [PosW-1:0] DETENT_3_RST  = 11'd1200;
    localparam logic [PosW-1:0] DETENT_4_RST  = 11'd1600;
    localparam logic [PosW-1:0] RESET_TOL_RST = 11'd3;
    localparam logic [PosW-1:0] SNAP_TOL_RST  = 11'd33;

    typedef struct packed {
        logic [PosW-1:0]   knob_sample;
        logic [IdW-1:0]    vehicle_id;
        logic [LevelW-1:0] vehicle_level;
    } in_word_t;

    typedef struct packed {
        logic              drive_on;
        logic              drive_ccw;
        logic              report_valid;
        logic [LevelW-1:0] report_level;
        logic [ModeW-1:0]  mode_now;
    } out_word_t;

endpackage

### hdl/motorized_knob_detent_snap.sv
// Top level of the motorized knob detent snap controller.
//
// The block takes one knob sample word per cycle, each tagged with the selected
// vehicle's id and stored level, and returns exactly one result word for each:
// motor drive enable and direction, a detent report and the mode after the
// sample. A sample goes into an input register, the mode decision, the nearest
// detent search over the four midpoints and the tolerance compares are done in
// one short combinational pass, and the result lands in an output register, so
// a word passes through both registers in turn and a new word can be
// accepted every cycle while the output side keeps up. The mode and the last
// vehicle id advance as each word moves from the input register to the output
// register, so back-to-back words see each other's state exactly in order. A
// stall on the result side holds the output register and backs up into the
// input register; the sample side stalls only when both are full. Detent
// positions and the two tolerances sit in APB registers at byte addresses
// 0x00..0x18 (detent 0..4, reset tolerance, snap tolerance); write them only
// while no word is in flight.
module motorized_knob_detent_snap (
    input  logic                            clk,
    input  logic                            rst_n,
    // sample channel
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  mkds_pkg::in_word_t              sample,
    // result channel
    output logic                            result_valid,
    input  logic                            result_stall,
    output mkds_pkg::out_word_t             result,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mkds_pkg::CfgAddrW-1:0]   paddr,
    input  logic [mkds_pkg::CfgDataW-1:0]   pwdata,
    output logic [mkds_pkg::CfgDataW-1:0]   prdata,
    output logic                            pready
);

    localparam int PosW = mkds_pkg::PosW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [mkds_pkg::NDetents-1:0][PosW-1:0] detent_reg;
    logic [PosW-1:0]                         reset_tol_reg;
    logic [PosW-1:0]                         snap_tol_reg;
    logic [mkds_pkg::CfgIdxW-1:0]            cfg_idx;
    logic                                    cfg_wr;
    logic [PosW-1:0]                         cfg_val;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[mkds_pkg::CfgAddrW-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_val = pwdata[PosW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detent_reg[0] <= mkds_pkg::DETENT_0_RST;
            detent_reg[1] <= mkds_pkg::DETENT_1_RST;
            detent_reg[2] <= mkds_pkg::DETENT_2_RST;
            detent_reg[3] <= mkds_pkg::DETENT_3_RST;
            detent_reg[4] <= mkds_pkg::DETENT_4_RST;
            reset_tol_reg <= mkds_pkg::RESET_TOL_RST;
            snap_tol_reg  <= mkds_pkg::SNAP_TOL_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                mkds_pkg::REG_DETENT_0:  detent_reg[0] <= cfg_val;
                mkds_pkg::REG_DETENT_1:  detent_reg[1] <= cfg_val;
                mkds_pkg::REG_DETENT_2:  detent_reg[2] <= cfg_val;
                mkds_pkg::REG_DETENT_3:  detent_reg[3] <= cfg_val;
                mkds_pkg::REG_DETENT_4:  detent_reg[4] <= cfg_val;
                mkds_pkg::REG_RESET_TOL: reset_tol_reg <= cfg_val;
                mkds_pkg::REG_SNAP_TOL:  snap_tol_reg  <= cfg_val;
                default:                 ;  // drop writes beyond the map
            endcase
        end
    end

    // Read back; unmapped addresses return zero.
    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            mkds_pkg::REG_DETENT_0:  prdata[PosW-1:0] = detent_reg[0];
            mkds_pkg::REG_DETENT_1:  prdata[PosW-1:0] = detent_reg[1];
            mkds_pkg::REG_DETENT_2:  prdata[PosW-1:0] = detent_reg[2];
            mkds_pkg::REG_DETENT_3:  prdata[PosW-1:0] = detent_reg[3];
            mkds_pkg::REG_DETENT_4:  prdata[PosW-1:0] = detent_reg[4];
            mkds_pkg::REG_RESET_TOL: prdata[PosW-1:0] = reset_tol_reg;
            mkds_pkg::REG_SNAP_TOL:  prdata[PosW-1:0] = snap_tol_reg;
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register -> decision logic -> output register
    // ------------------------------------------------------------------
    logic                 in_valid_reg;
    mkds_pkg::in_word_t   in_reg;
    logic                 out_valid_reg;
    mkds_pkg::out_word_t  out_reg;
    mkds_pkg::out_word_t  out_next;
    logic                 advance;
    logic                 take;

    // Advance the input register into the output register when the latter
    // is empty or being drained this cycle.
    assign advance      = in_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = in_valid_reg && !advance;
    assign take         = sample_valid && !sample_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= sample;
        if (advance)
            out_reg <= out_next;
    end

    // ------------------------------------------------------------------
    // Controller state: mode and last seen vehicle
    // ------------------------------------------------------------------
    logic [mkds_pkg::ModeW-1:0] mode_reg;
    logic [mkds_pkg::ModeW-1:0] mode_next;
    logic [mkds_pkg::IdW-1:0]   known_vehicle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= mkds_pkg::MODE_UNKNOWN;
            known_vehicle_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg          <= mode_next;
            known_vehicle_reg <= in_reg.vehicle_id;
        end
    end

    // ------------------------------------------------------------------
    // Decision logic for the word in the input register
    // ------------------------------------------------------------------
    logic [mkds_pkg::ModeW-1:0]       mode_cur;
    logic [PosW-1:0]                  target;
    logic [PosW-1:0]                  reset_dist;
    logic [PosW:0]                    twice_sample;
    logic [3:0][PosW:0]               mid_sum;
    logic [mkds_pkg::LevelW-1:0]      nearest;
    logic [PosW-1:0]                  near_pos;
    logic [PosW-1:0]                  snap_dist;
    logic [PosW-1:0]                  knob;

    assign knob = in_reg.knob_sample;

    // A new vehicle id forces a return to its stored detent.
    assign mode_cur = (in_reg.vehicle_id != known_vehicle_reg) ? mkds_pkg::MODE_RESETTING
                                                              : mode_reg;

    // Out-of-range levels target position zero.
    always_comb
    begin
        if (in_reg.vehicle_level < mkds_pkg::LevelW'(mkds_pkg::NDetents))
            target = detent_reg[in_reg.vehicle_level];
        else
            target = '0;
    end

    assign reset_dist = (knob > target) ? (knob - target) : (target - knob);

    // Midpoint search: first k with 2*sample < pos[k] + pos[k+1] wins,
    // ties on a midpoint go to the higher detent.
    assign twice_sample = {knob, 1'b0};

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            mid_sum[k] = {1'b0, detent_reg[k]} + {1'b0, detent_reg[k+1]};
        nearest = mkds_pkg::LevelW'(mkds_pkg::NDetents - 1);
        for (int k = 3; k >= 0; k--)
        begin
            if (twice_sample < mid_sum[k])
                nearest = mkds_pkg::LevelW'(k);
        end
    end

    assign near_pos  = detent_reg[nearest];
    assign snap_dist = (knob > near_pos) ? (knob - near_pos) : (near_pos - knob);

    always_comb
    begin
        out_next  = '0;
        mode_next = mode_cur;
        case (mode_cur)
            mkds_pkg::MODE_RESETTING:
            begin
                if (reset_dist < reset_tol_reg)
                    mode_next = mkds_pkg::MODE_ACCEPTING;  // arrived, stop quietly
                else
                begin
                    out_next.drive_on  = 1'b1;
                    out_next.drive_ccw = (knob > target);
                end
            end
            mkds_pkg::MODE_ACCEPTING:
            begin
                if (snap_dist < snap_tol_reg)
                begin
                    out_next.report_valid = 1'b1;
                    out_next.report_level = nearest;
                end
                else
                begin
                    out_next.drive_on  = 1'b1;
                    out_next.drive_ccw = (knob > near_pos);
                end
            end
            default:
                ;  // unknown mode: hold motor stopped, no report
        endcase
        out_next.mode_now = mode_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stopped_no_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.drive_on) |-> !result.drive_ccw)
        else $error("direction set while motor stopped");

    a_report_only_accepting: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.report_valid) |->
            (result.mode_now == mkds_pkg::MODE_ACCEPTING) && !result.drive_on)
        else $error("report outside accepting mode or while driving");

    a_report_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.report_valid) |->
            (result.report_level < mkds_pkg::LevelW'(mkds_pkg::NDetents)))
        else $error("reported level out of range");

    a_new_vehicle_leaves_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_reg.vehicle_id != known_vehicle_reg)) |=>
            (mode_reg != mkds_pkg::MODE_UNKNOWN))
        else $error("vehicle change did not leave unknown mode");

    a_state_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result.mode_now == mode_reg))
        else $error("result mode disagrees with controller state");

endmodule

### tb/tb_motorized_knob_detent_snap.sv
// Self-checking testbench for the motorized knob detent snap controller.
import mkds_pkg::*;

class knob_snap_scoreboard;
    logic [PosW-1:0]  detent [NDetents];
    logic [PosW-1:0]  reset_tol;
    logic [PosW-1:0]  snap_tol;
    logic [ModeW-1:0] mode;
    logic [IdW-1:0]   known_id;
    out_word_t        words_due [$];
    int               mismatches;

    function new();
        detent[0]  = DETENT_0_RST;
        detent[1]  = DETENT_1_RST;
        detent[2]  = DETENT_2_RST;
        detent[3]  = DETENT_3_RST;
        detent[4]  = DETENT_4_RST;
        reset_tol  = RESET_TOL_RST;
        snap_tol   = SNAP_TOL_RST;
        mode       = MODE_UNKNOWN;
        known_id   = '0;
        mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [PosW-1:0] v);
        case (idx)
            REG_RESET_TOL: reset_tol = v;
            REG_SNAP_TOL:  snap_tol = v;
            default:       if (idx < NDetents) detent[idx] = v;
        endcase
    endfunction

    function logic [PosW-1:0] reg_value(logic [CfgIdxW-1:0] idx);
        case (idx)
            REG_RESET_TOL: return reset_tol;
            REG_SNAP_TOL:  return snap_tol;
            default:       return (idx < NDetents) ? detent[idx] : '0;
        endcase
    endfunction

    function void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function void check_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] got);
        if (got[PosW-1:0] !== reg_value(idx))
            note_mismatch($sformatf("register %0d read %0d, expected %0d",
                                    idx, got[PosW-1:0], reg_value(idx)));
    endfunction

    function int span(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Motor command, report and mode for one sample; advances mode and id.
    function out_word_t snap_decision(in_word_t w);
        out_word_t r;
        int        pos;
        int        target;
        int        nearest;
        int        det;
        bit        found;
        r   = '0;
        pos = int'(w.knob_sample);
        if (w.vehicle_id != known_id)
        begin
            mode     = MODE_RESETTING;
            known_id = w.vehicle_id;
        end
        case (mode)
            MODE_RESETTING:
            begin
                // out-of-range levels aim at position zero
                target = (w.vehicle_level < NDetents) ? int'(detent[w.vehicle_level]) : 0;
                if (span(pos, target) < int'(reset_tol))
                begin
                    mode = MODE_ACCEPTING;
                end
                else
                begin
                    r.drive_on  = 1'b1;
                    r.drive_ccw = (pos > target);
                end
            end
            MODE_ACCEPTING:
            begin
                // midpoints in fixed order, ties go to the upper detent
                nearest = NDetents - 1;
                found   = 1'b0;
                for (int k = 0; k < NDetents - 1; k++)
                begin
                    if (!found && 2 * pos < int'(detent[k]) + int'(detent[k + 1]))
                    begin
                        nearest = k;
                        found   = 1'b1;
                    end
                end
                det = int'(detent[nearest]);
                if (span(pos, det) < int'(snap_tol))
                begin
                    r.report_valid = 1'b1;
                    r.report_level = nearest[LevelW-1:0];
                end
                else
                begin
                    r.drive_on  = 1'b1;
                    r.drive_ccw = (pos > det);
                end
            end
            default: ;
        endcase
        r.mode_now = mode;
        return r;
    endfunction

    function void note_sample(in_word_t w);
        words_due.push_back(snap_decision(w));
    endfunction

    function string show(out_word_t o);
        return $sformatf("on=%0d ccw=%0d rep=%0d lvl=%0d mode=%0d",
                         o.drive_on, o.drive_ccw, o.report_valid, o.report_level, o.mode_now);
    endfunction

    function void check_result(out_word_t got);
        out_word_t want;
        if (words_due.size() == 0)
        begin
            note_mismatch({"result with no sample pending: ", show(got)});
            return;
        end
        want = words_due.pop_front();
        if (got.drive_on !== want.drive_on || got.drive_ccw !== want.drive_ccw ||
            got.report_valid !== want.report_valid ||
            got.report_level !== want.report_level || got.mode_now !== want.mode_now)
            note_mismatch({"expected ", show(want), " got ", show(got)});
    endfunction
endclass

module tb_motorized_knob_detent_snap;

    localparam int HoldCycles  = 80;    // length of the forced result-side hold-off
    localparam int QuietLimit  = 3000;  // cycles without any accepted word before giving up
    localparam int PhaseItems  = 220;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                sample_valid;
    logic                sample_stall;
    in_word_t            sample;
    logic                result_valid;
    logic                result_stall;
    out_word_t           result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CfgAddrW-1:0] paddr;
    logic [CfgDataW-1:0] pwdata;
    logic [CfgDataW-1:0] prdata;
    logic                pready;

    knob_snap_scoreboard sb;
    int                  quiet_cycles = 0;
    bit                  hold_off_req = 1'b0;
    logic [IdW-1:0]      cur_id = '0;
    logic [LevelW-1:0]   cur_level = '0;

    motorized_knob_detent_snap dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Sample both channels at the rising edge. Note the incoming word before
    // checking the outgoing one so an unregistered path would still line up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                sb.note_sample(sample);
            if (result_valid && !result_stall)
                sb.check_result(result);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog: drop the run if nothing moves for too long.
    initial
    begin
        while (quiet_cycles < QuietLimit)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: stall on a pattern of its own. Each stretch picks a stall
    // density, zero included, so some stretches run with no stall at all.
    // On request, hold off for a long, fixed stretch to back the block up.
    initial
    begin
        int pct;
        int stretch;
        result_stall = 1'b0;
        forever
        begin
            case ($urandom_range(0, 3))
                0:       pct = 0;
                1:       pct = 20;
                2:       pct = 50;
                default: pct = 90;
            endcase
            stretch = $urandom_range(10, 150);
            repeat (stretch)
            begin
                @(negedge clk);
                if (hold_off_req)
                begin
                    hold_off_req = 1'b0;
                    result_stall <= 1'b1;
                    repeat (HoldCycles) @(negedge clk);
                end
                result_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [PosW-1:0] pos, input logic [IdW-1:0] id,
                             input logic [LevelW-1:0] lvl);
        in_word_t w;
        w.knob_sample   = pos;
        w.vehicle_id    = id;
        w.vehicle_level = lvl;
        @(negedge clk);
        sample_valid <= 1'b1;
        sample       <= w;
        do @(posedge clk); while (sample_stall);
    endtask

    // Drop valid for a gap; n sets its length.
    task automatic pause_samples(input int n);
        @(negedge clk);
        sample_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic reg_read(input logic [CfgIdxW-1:0] idx, output logic [CfgDataW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write one register (junk in the unused upper bits), then read it back.
    task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [PosW-1:0] v);
        logic [CfgDataW-1:0] word;
        logic [CfgDataW-1:0] back;
        word           = $urandom;
        word[PosW-1:0] = v;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_read(idx, back);
        sb.check_reg(idx, back);
    endtask

    // Wait until every result is back, then let the pipeline settle.
    task automatic drain;
        pause_samples(1);
        while (sb.words_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random sessions: a vehicle change now and then, samples clustered around
    // the reset target, the detents and the midpoints, plus some pure noise.
    // When hold_at is reached, ask for the long hold-off and keep offering
    // the next 40 words without gaps so the block fills and stalls its input.
    task automatic run_random(input int n_items, input int hold_at);
        int sent;
        int burst;
        int gap;
        int kind;
        int k;
        int target;
        int pos;
        int calm_until;
        sent       = 0;
        calm_until = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < n_items; b++)
            begin
                if (sent == hold_at)
                begin
                    hold_off_req = 1'b1;
                    calm_until   = sent + 40;
                end
                if ($urandom_range(0, 99) < 4)
                begin
                    case ($urandom_range(0, 9))
                        0:       cur_id = '0;
                        1:       cur_id = '1;
                        2:       ;  // same vehicle picked again
                        default: cur_id = IdW'($urandom);
                    endcase
                    cur_level = ($urandom_range(0, 9) == 0) ? LevelW'($urandom_range(5, 7))
                                                            : LevelW'($urandom_range(0, 4));
                end
                else if ($urandom_range(0, 99) == 0)
                begin
                    cur_level = LevelW'($urandom_range(0, 7));
                end
                target = (cur_level < NDetents) ? int'(sb.detent[cur_level]) : 0;
                kind   = $urandom_range(0, 9);
                if (kind < 4)
                begin
                    pos = target + int'($urandom_range(0, 16)) - 8;
                end
                else if (kind < 7)
                begin
                    k   = $urandom_range(0, NDetents - 1);
                    pos = int'(sb.detent[k]) + int'($urandom_range(0, 2 * sb.snap_tol + 4))
                          - int'(sb.snap_tol) - 2;
                end
                else if (kind < 8)
                begin
                    k   = $urandom_range(0, NDetents - 2);
                    pos = (int'(sb.detent[k]) + int'(sb.detent[k + 1])) / 2
                          + int'($urandom_range(0, 1));
                end
                else
                begin
                    pos = $urandom_range(0, 2047);
                end
                if (pos < 0)
                    pos = 0;
                if (pos > 2047)
                    pos = 2047;
                send_word(pos[PosW-1:0], cur_id, cur_level);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0 && sent >= calm_until)
                pause_samples(gap);
        end
    endtask

    initial
    begin
        logic [CfgDataW-1:0] rd;
        logic [PosW-1:0]     pos [NDetents];
        logic [PosW-1:0]     rtol;
        logic [PosW-1:0]     stol;
        int                  step;

        sb           = new();
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values of all registers
        for (int i = REG_DETENT_0; i <= REG_SNAP_TOL; i++)
        begin
            reg_read(i[CfgIdxW-1:0], rd);
            sb.check_reg(i[CfgIdxW-1:0], rd);
        end

        // Directed words on the reset settings.
        send_word(11'd0,    16'd0,      3'd0);  // id zero: nothing changes, mode unknown
        send_word(11'd2047, 16'd0,      3'd4);
        send_word(11'd0,    16'd1,      3'd2);  // new id: drive clockwise toward 800
        send_word(11'd2047, 16'd1,      3'd2);  // drive counterclockwise
        send_word(11'd802,  16'd1,      3'd2);  // arrival: motor off, no report
        send_word(11'd800,  16'd1,      3'd2);  // resting at detent two
        send_word(11'd600,  16'd1,      3'd2);  // on the midpoint: upper detent wins
        send_word(11'd599,  16'd1,      3'd2);
        send_word(11'd0,    16'd1,      3'd0);
        send_word(11'd1632, 16'd1,      3'd4);  // just inside snap tolerance
        send_word(11'd1633, 16'd1,      3'd4);  // just outside
        send_word(11'd1567, 16'd1,      3'd4);  // exactly at tolerance: still outside
        send_word(11'd2047, 16'd1,      3'd3);
        send_word(11'd2047, 16'd2,      3'd7);  // level out of range aims at zero
        send_word(11'd2,    16'd2,      3'd7);
        send_word(11'd1400, 16'd2,      3'd7);
        send_word(11'd0,    16'hFFFF,   3'd5);  // arrives on the first sample
        send_word(11'd1203, 16'hFFFF,   3'd6);
        send_word(11'd1199, 16'h8000,   3'd3);
        send_word(11'd1200, 16'h8000,   3'd3);
        send_word(11'd400,  16'h8000,   3'd1);
        send_word(11'd1197, 16'd0,      3'd1);  // back to id zero: it is a change now
        send_word(11'd403,  16'd0,      3'd1);
        send_word(11'd397,  16'd0,      3'd1);
        send_word(11'd401,  16'd0,      3'd1);

        // Reset settings first, with the long hold-off in the middle, then
        // extremes and random layouts. Reconfigure only once the block is empty.
        run_random(PhaseItems, 100);
        for (int phase = 1; phase <= 5; phase++)
        begin
            drain();
            case (phase)
                1:
                begin
                    for (int i = 0; i < NDetents; i++)
                        pos[i] = '1;
                    rtol = '1;
                    stol = '1;
                end
                2:
                begin
                    for (int i = 0; i < NDetents; i++)
                        pos[i] = '0;
                    rtol = '0;
                    stol = '0;
                end
                3:
                begin
                    step = $urandom_range(0, 400);
                    for (int i = 0; i < NDetents; i++)
                    begin
                        pos[i] = (step > 2047) ? 11'd2047 : step[PosW-1:0];
                        step   = step + $urandom_range(0, 420);
                    end
                    rtol = PosW'($urandom_range(0, 8));
                    stol = PosW'($urandom_range(0, 120));
                end
                4:
                begin
                    // unordered layout
                    for (int i = 0; i < NDetents; i++)
                        pos[i] = PosW'($urandom_range(0, 2047));
                    rtol = PosW'($urandom_range(0, 40));
                    stol = PosW'($urandom_range(0, 300));
                end
                default:
                begin
                    // crowded detents: midpoint ties and exact arrivals
                    step = $urandom_range(0, 2030);
                    for (int i = 0; i < NDetents; i++)
                    begin
                        pos[i] = step[PosW-1:0];
                        step   = step + $urandom_range(0, 4);
                    end
                    rtol = 11'd1;
                    stol = 11'd1;
                end
            endcase
            for (int i = 0; i < NDetents; i++)
                reg_write(i[CfgIdxW-1:0], pos[i]);
            reg_write(REG_RESET_TOL, rtol);
            reg_write(REG_SNAP_TOL, stol);
            run_random(PhaseItems, -1);
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.words_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
